### design/eptc_pkg.sv
// Package for the event point triplet combiner: constants, item structs, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eptc_pkg;
    localparam int MAX_PEAKS_DEF    = 64;
    localparam int MAX_TRIPLETS_DEF = 32;
    localparam int TIME_W = 23;
    localparam int FREQ_W = 9;
    localparam int MAG_W  = 32;
    localparam int PEAK_W = TIME_W + FREQ_W + MAG_W;
    localparam int CFG_W  = 9;

    localparam logic [1:0] CFG_MIN_TIME = 2'd0;
    localparam logic [1:0] CFG_MAX_TIME = 2'd1;
    localparam logic [1:0] CFG_MIN_FREQ = 2'd2;
    localparam logic [1:0] CFG_MAX_FREQ = 2'd3;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_TRIPLET = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] peak_time;
        logic [FREQ_W-1:0] peak_freq;
        logic [MAG_W-1:0]  peak_mag;
        logic [TIME_W-1:0] block_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              last_of_run;
        logic [TIME_W-1:0] time_first;
        logic [TIME_W-1:0] time_second;
        logic [TIME_W-1:0] time_third;
        logic [FREQ_W-1:0] freq_first;
        logic [FREQ_W-1:0] freq_second;
        logic [FREQ_W-1:0] freq_third;
        logic [MAG_W-1:0]  mag_first;
        logic [MAG_W-1:0]  mag_second;
        logic [MAG_W-1:0]  mag_third;
        logic [31:0]       tally;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [FREQ_W-1:0] f;
        logic [MAG_W-1:0]  m;
    } peak_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_I_RD,
        ST_I_CHK,
        ST_J_RD,
        ST_J_CHK,
        ST_K_RD,
        ST_K_CHK,
        ST_P_LAST,
        ST_P_LAST_W,
        ST_P_RD,
        ST_P_CHK,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

### design/eptc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module eptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/event_point_triplet_combiner.sv
// Top level of the event point triplet combiner: control sequencer over a peak RAM.
// Depends on eptc_pkg and eptc_ram.
// Store: the ack is on the result ports in the cycle after start is accepted; busy
// stays low, so stores can follow back to back. Extract: each scanned (i,j,k) entry
// is read through the single RAM read port and checked, an exhausted scan steps
// the outer index, then the last peak is read for the cutoff and each peak is read
// and pruned; busy is high from accept until the done item is issued.
// Reset (rst_n low, asynchronous) empties the table, clears the total and loads
// the default gap limits; results are a one-cycle strobe, never stalled.
`timescale 1ns / 1ps
`default_nettype none
module event_point_triplet_combiner #(
    parameter int MAX_PEAKS    = eptc_pkg::MAX_PEAKS_DEF,
    parameter int MAX_TRIPLETS = eptc_pkg::MAX_TRIPLETS_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire eptc_pkg::in_item_t    in_item,
    output logic                       result_valid,
    output eptc_pkg::out_item_t        result,
    input  wire                        cfg_we,
    input  wire [1:0]                  cfg_index,
    input  wire [eptc_pkg::CFG_W-1:0]  cfg_data
);
    localparam int AW = $clog2(MAX_PEAKS);
    localparam int CW = $clog2(MAX_PEAKS + 1);
    localparam int BW = $clog2(MAX_TRIPLETS + 1);
    localparam int TW = eptc_pkg::TIME_W;
    localparam int FW = eptc_pkg::FREQ_W;

    eptc_pkg::state_t state_reg, state_next;
    logic [7:0]    min_t_reg, max_t_reg;
    logic [FW-1:0] min_f_reg, max_f_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, kept_reg, kept_next;
    logic [BW-1:0] batch_reg, batch_next;
    logic [31:0]   total_reg, total_next;
    eptc_pkg::peak_t p1_reg, p1_next, p2_reg, p2_next;
    logic [TW-1:0] blk_reg, blk_next;
    logic [TW:0]   cut_reg, cut_next;
    logic          rv_next;
    eptc_pkg::out_item_t res_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    eptc_pkg::peak_t wdata, rdata;

    eptc_ram #(.WIDTH(eptc_pkg::PEAK_W), .DEPTH(MAX_PEAKS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    function automatic logic gaps_ok(input logic [TW-1:0] ta, input logic [TW-1:0] tb,
                                     input logic [FW-1:0] fa, input logic [FW-1:0] fb,
                                     input logic [7:0] mint, input logic [7:0] maxt,
                                     input logic [FW-1:0] minf, input logic [FW-1:0] maxf);
        logic [FW-1:0] df;
        logic          ge;
        ge = (tb >= ta);
        df = (fa >= fb) ? fa - fb : fb - fa;
        return ge && ((tb - ta) >= {15'd0, mint}) && ((tb - ta) <= {15'd0, maxt})
            && (df >= minf) && (df <= maxf);
    endfunction

    logic          far_j, far_k;
    logic [TW:0]   recent;
    assign far_j  = (rdata.t >= p1_reg.t) && ((rdata.t - p1_reg.t) > {15'd0, max_t_reg});
    assign far_k  = (rdata.t >= p2_reg.t) && ((rdata.t - p2_reg.t) > {15'd0, max_t_reg});
    assign recent = {1'b0, blk_reg} - {16'd0, max_t_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= eptc_pkg::ST_IDLE;
            min_t_reg    <= 8'd2;
            max_t_reg    <= 8'd33;
            min_f_reg    <= 9'd1;
            max_f_reg    <= 9'd128;
            count_reg    <= '0;
            batch_reg    <= '0;
            total_reg    <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            batch_reg    <= batch_next;
            total_reg    <= total_next;
            result_valid <= rv_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    eptc_pkg::CFG_MIN_TIME: min_t_reg <= cfg_data[7:0];
                    eptc_pkg::CFG_MAX_TIME: max_t_reg <= cfg_data[7:0];
                    eptc_pkg::CFG_MIN_FREQ: min_f_reg <= cfg_data;
                    eptc_pkg::CFG_MAX_FREQ: max_f_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        kept_reg <= kept_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        blk_reg  <= blk_next;
        cut_reg  <= cut_next;
        result   <= res_next;
    end

    assign busy = (state_reg != eptc_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        batch_next = batch_reg;
        total_next = total_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; kept_next = kept_reg;
        p1_next = p1_reg; p2_next = p2_reg; blk_next = blk_reg; cut_next = cut_reg;
        rv_next  = 1'b0;
        res_next = '0;
        we = 1'b0; waddr = count_reg[AW-1:0]; wdata = '0; raddr = i_reg[AW-1:0];
        unique case (state_reg)
            eptc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (in_item.opcode == eptc_pkg::OP_STORE)
                    begin
                        rv_next = 1'b1;
                        res_next.kind = eptc_pkg::KIND_ACK;
                        res_next.last_of_run = 1'b1;
                        if (count_reg < CW'(MAX_PEAKS))
                        begin
                            we = 1'b1;
                            wdata.t = in_item.peak_time;
                            wdata.f = in_item.peak_freq;
                            wdata.m = in_item.peak_mag;
                            count_next = count_reg + 1'b1;
                            res_next.tally = 32'(count_reg + 1'b1);
                        end
                        else
                        begin
                            res_next.tally = 32'(count_reg) | 32'h8000_0000;
                        end
                    end
                    else
                    begin
                        batch_next = '0;
                        blk_next = in_item.block_index;
                        i_next = '0;
                        state_next = eptc_pkg::ST_I_RD;
                    end
                end
            end
            eptc_pkg::ST_I_RD:
            begin
                raddr = i_reg[AW-1:0];
                state_next = (i_reg < count_reg) ? eptc_pkg::ST_I_CHK
                                                 : eptc_pkg::ST_P_LAST;
            end
            eptc_pkg::ST_I_CHK:
            begin
                p1_next = rdata;
                if ((rdata.t == '0 && rdata.f == '0) ||
                    ($signed({1'b0, rdata.t}) > $signed(recent)))
                begin
                    state_next = eptc_pkg::ST_P_LAST;
                end
                else
                begin
                    j_next = i_reg + 1'b1;
                    state_next = eptc_pkg::ST_J_RD;
                end
            end
            eptc_pkg::ST_J_RD:
            begin
                raddr = j_reg[AW-1:0];
                if (j_reg < count_reg)
                begin
                    state_next = eptc_pkg::ST_J_CHK;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = eptc_pkg::ST_I_RD;
                end
            end
            eptc_pkg::ST_J_CHK:
            begin
                p2_next = rdata;
                if (far_j)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = eptc_pkg::ST_I_RD;
                end
                else if (gaps_ok(p1_reg.t, rdata.t, p1_reg.f, rdata.f,
                                 min_t_reg, max_t_reg, min_f_reg, max_f_reg))
                begin
                    k_next = j_reg + 1'b1;
                    state_next = eptc_pkg::ST_K_RD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = eptc_pkg::ST_J_RD;
                end
            end
            eptc_pkg::ST_K_RD:
            begin
                raddr = k_reg[AW-1:0];
                if (k_reg < count_reg)
                begin
                    state_next = eptc_pkg::ST_K_CHK;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = eptc_pkg::ST_J_RD;
                end
            end
            eptc_pkg::ST_K_CHK:
            begin
                if (far_k)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = eptc_pkg::ST_J_RD;
                end
                else
                begin
                    if (gaps_ok(p2_reg.t, rdata.t, p2_reg.f, rdata.f,
                                min_t_reg, max_t_reg, min_f_reg, max_f_reg)
                        && batch_reg < BW'(MAX_TRIPLETS))
                    begin
                        rv_next = 1'b1;
                        res_next.kind = eptc_pkg::KIND_TRIPLET;
                        res_next.time_first = p1_reg.t;
                        res_next.time_second = p2_reg.t;
                        res_next.time_third = rdata.t;
                        res_next.freq_first = p1_reg.f;
                        res_next.freq_second = p2_reg.f;
                        res_next.freq_third = rdata.f;
                        res_next.mag_first = p1_reg.m;
                        res_next.mag_second = p2_reg.m;
                        res_next.mag_third = rdata.m;
                        batch_next = batch_reg + 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                    state_next = eptc_pkg::ST_K_RD;
                end
            end
            eptc_pkg::ST_P_LAST:
            begin
                raddr = AW'(count_reg - 1'b1);
                i_next = '0;
                kept_next = '0;
                state_next = (count_reg == '0) ? eptc_pkg::ST_DONE
                                               : eptc_pkg::ST_P_LAST_W;
            end
            eptc_pkg::ST_P_LAST_W:
            begin
                cut_next = {1'b0, rdata.t} - {16'd0, max_t_reg};
                state_next = eptc_pkg::ST_P_RD;
            end
            eptc_pkg::ST_P_RD:
            begin
                raddr = i_reg[AW-1:0];
                if (i_reg < count_reg)
                begin
                    state_next = eptc_pkg::ST_P_CHK;
                end
                else
                begin
                    count_next = kept_reg;
                    state_next = eptc_pkg::ST_DONE;
                end
            end
            eptc_pkg::ST_P_CHK:
            begin
                if ($signed({1'b0, rdata.t}) > $signed(cut_reg))
                begin
                    we = 1'b1;
                    waddr = kept_reg[AW-1:0];
                    wdata = rdata;
                    kept_next = kept_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                state_next = eptc_pkg::ST_P_RD;
            end
            eptc_pkg::ST_DONE:
            begin
                rv_next = 1'b1;
                res_next.kind = eptc_pkg::KIND_DONE;
                res_next.last_of_run = 1'b1;
                total_next = total_reg + 32'(batch_reg);
                res_next.tally = total_reg + 32'(batch_reg);
                state_next = eptc_pkg::ST_IDLE;
            end
            default: state_next = eptc_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
